// ----- hw/rtl/lici_pkg.sv -----
// shared types, constants and s-box tables for the 64/128 block cipher core
// no dependencies; imported by the round unit, the key unit and the top level
package lici_pkg;

   // key and block geometry
   localparam int KEY_W     = 128;
   localparam int HALF_W    = 32;
   localparam int KWORD_W   = 64;
   localparam int KEY_ROT   = 13;
   localparam int RC_POS    = 59;
   localparam int RC_W      = 5;
   localparam int RC_IDX_W  = 5;
   localparam int RC_COUNT  = 31;
   localparam logic [7:0] RC_MASK = 8'h1F;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW  = 2'd1;

   // 4-bit s-box and its inverse
   localparam logic [3:0] FWD_BOX [16] = '{
      4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
      4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
   };
   localparam logic [3:0] INV_BOX [16] = '{
      4'h5, 4'hE, 4'hF, 4'h8, 4'hC, 4'h1, 4'h2, 4'hD,
      4'hB, 4'h4, 4'h6, 4'h3, 4'h0, 4'h7, 4'h9, 4'hA
   };

   // round constants, masked to five bits on use
   localparam logic [7:0] RC_TABLE [RC_COUNT] = '{
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
      8'h13, 8'h23, 8'h43, 8'h83, 8'h15, 8'h25, 8'h45, 8'h85,
      8'h16, 8'h26, 8'h46, 8'h86, 8'h1A, 8'h2A, 8'h4A, 8'h8A,
      8'h1C, 8'h2C, 8'h4C, 8'h8C, 8'h1F, 8'h2F, 8'h4F
   };

   // control from the sequencer to the key unit
   typedef struct packed {
      logic            load;
      logic            fwd;
      logic            inv;
      logic [RC_W-1:0] rc;
   } key_ctrl_type;

   // round constant lookup, index past the table gives zero
   function automatic logic [RC_W-1:0] round_const(input logic [RC_IDX_W-1:0] idx);
      logic [7:0] v;
      v = 8'h00;
      if (int'(idx) < RC_COUNT) v = RC_TABLE[idx] & RC_MASK;
      return v[RC_W-1:0];
   endfunction

endpackage

// ----- hw/rtl/lici_round.sv -----
// one cipher round, forward or inverse, as a shared combinational unit
// depends on lici_pkg for the s-box tables
module lici_round
   import lici_pkg::*;
(
   input  logic              dec,
   input  logic [HALF_W-1:0] left,
   input  logic [HALF_W-1:0] right,
   input  logic [KWORD_W-1:0] rkey,
   output logic [HALF_W-1:0] left_nx,
   output logic [HALF_W-1:0] right_nx
);

   logic [HALF_W-1:0] kr;
   logic [HALF_W-1:0] kl;
   logic [HALF_W-1:0] lp_enc;
   logic [HALF_W-1:0] nl_enc;
   logic [HALF_W-1:0] nr_enc;
   logic [HALF_W-1:0] lp_dec;
   logic [HALF_W-1:0] nl_dec;
   logic [HALF_W-1:0] nr_dec;

   assign kr = rkey[HALF_W-1:0];
   assign kl = rkey[KWORD_W-1:HALF_W];

   // nibble substitution, each nibble independent
   always_comb begin
      for (int i = 0; i < HALF_W / 4; i++) begin
         lp_enc[4*i +: 4] = FWD_BOX[left[4*i +: 4]];
      end
   end

   // forward round: rotl3 then rotr7
   always_comb begin
      logic [HALF_W-1:0] t;
      logic [HALF_W-1:0] u;
      t      = lp_enc ^ right ^ kr;
      nl_enc = {t[HALF_W-4:0], t[HALF_W-1:HALF_W-3]};
      u      = lp_enc ^ nl_enc ^ kl;
      nr_enc = {u[6:0], u[HALF_W-1:7]};
   end

   // inverse round: undo the rotations, then the substitution
   always_comb begin
      lp_dec = {right[HALF_W-8:0], right[HALF_W-1:HALF_W-7]} ^ kl ^ left;
      nr_dec = {left[2:0], left[HALF_W-1:3]} ^ lp_dec ^ kr;
      for (int i = 0; i < HALF_W / 4; i++) begin
         nl_dec[4*i +: 4] = INV_BOX[lp_dec[4*i +: 4]];
      end
   end

   assign left_nx  = dec ? nl_dec : nl_enc;
   assign right_nx = dec ? nr_dec : nr_enc;

endmodule

// ----- hw/rtl/lici_key_unit.sv -----
// working key register with forward and inverse key update
// depends on lici_pkg for the s-box, key geometry and control struct
module lici_key_unit
   import lici_pkg::*;
(
   input  logic               clock,
   input  key_ctrl_type       ctrl,
   input  logic [KEY_W-1:0]   load_key,
   output logic [KWORD_W-1:0] key_low_cur,
   output logic [KWORD_W-1:0] key_low_inv
);

   logic [KEY_W-1:0] key_ff;
   logic [KEY_W-1:0] key_in;
   logic [KEY_W-1:0] fwd_key;
   logic [KEY_W-1:0] inv_key;

   // forward update: rotl13, s-box on bits 7..4, constant into bits 63..59
   always_comb begin
      logic [KEY_W-1:0]   rot;
      logic [KWORD_W-1:0] lo;
      rot = {key_ff[KEY_W-1-KEY_ROT:0], key_ff[KEY_W-1:KEY_W-KEY_ROT]};
      lo  = rot[KWORD_W-1:0];
      lo[7:4] = FWD_BOX[lo[7:4]];
      lo[KWORD_W-1:RC_POS] = lo[KWORD_W-1:RC_POS] ^ ctrl.rc;
      fwd_key = {rot[KEY_W-1:KWORD_W], lo};
   end

   // inverse update: constant, inverse s-box, rotr13
   always_comb begin
      logic [KWORD_W-1:0] lo;
      logic [KEY_W-1:0]   tk;
      lo = key_ff[KWORD_W-1:0];
      lo[KWORD_W-1:RC_POS] = lo[KWORD_W-1:RC_POS] ^ ctrl.rc;
      lo[7:4] = INV_BOX[lo[7:4]];
      tk = {key_ff[KEY_W-1:KWORD_W], lo};
      inv_key = {tk[KEY_ROT-1:0], tk[KEY_W-1:KEY_ROT]};
   end

   // next key select
   always_comb begin
      key_in = key_ff;
      if (ctrl.load) key_in = load_key;
      else if (ctrl.fwd) key_in = fwd_key;
      else if (ctrl.inv) key_in = inv_key;
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key_low_cur = key_ff[KWORD_W-1:0];
   assign key_low_inv = inv_key[KWORD_W-1:0];

endmodule

// ----- hw/rtl/lici_block_cipher_enc_dec.sv -----
// 64/128 block cipher core, one round per cycle in the round states, through a shared round unit.
// encrypt runs the rounds straight from the request; decrypt first walks the key schedule
// forward to its end, then runs the rounds back with the inverted keys.
// no new request is taken while busy; the next one is accepted once the block is done.
// the result strobe cannot be stalled; busy drops in the strobe cycle.
// synchronous reset clears the sequencer, the strobe and both key registers.
module lici_block_cipher_enc_dec
   import lici_pkg::*;
#(
   parameter int ROUNDS = 31
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_action,
   input  logic [HALF_W-1:0]    req_left_in,
   input  logic [HALF_W-1:0]    req_right_in,
   output logic                 rsp_valid,
   output logic [HALF_W-1:0]    rsp_left_out,
   output logic [HALF_W-1:0]    rsp_right_out,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [KWORD_W-1:0]   csr_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ENC,
      ST_KEYF,
      ST_DEC
   } state_type;

   localparam logic [RC_IDX_W-1:0] LAST_RND = RC_IDX_W'(ROUNDS - 1);
   localparam logic [RC_IDX_W-1:0] FIRST_RND = '0;

   state_type             state_ff;
   logic [RC_IDX_W-1:0]   rnd_ff;
   logic                  rsp_valid_ff;
   logic [HALF_W-1:0]     left_ff;
   logic [HALF_W-1:0]     right_ff;
   logic [KWORD_W-1:0]    key_high_ff;
   logic [KWORD_W-1:0]    key_low_ff;

   key_ctrl_type          key_ctrl;
   logic [KWORD_W-1:0]    key_low_cur;
   logic [KWORD_W-1:0]    key_low_inv;
   logic [KWORD_W-1:0]    rkey;
   logic                  dec_mode;
   logic [HALF_W-1:0]     left_nx;
   logic [HALF_W-1:0]     right_nx;
   logic                  accept;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // key configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_KEY_HIGH: key_high_ff <= csr_data;
            CSR_KEY_LOW:  key_low_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // key unit control
   always_comb begin
      key_ctrl.load = accept;
      key_ctrl.fwd  = (state_ff == ST_ENC) || (state_ff == ST_KEYF);
      key_ctrl.inv  = (state_ff == ST_DEC);
      key_ctrl.rc   = round_const(rnd_ff);
   end

   lici_key_unit u_key (
      .clock       (clock),
      .ctrl        (key_ctrl),
      .load_key    ({key_high_ff, key_low_ff}),
      .key_low_cur (key_low_cur),
      .key_low_inv (key_low_inv)
   );

   // decrypt rounds use the freshly inverted key in the same cycle
   assign dec_mode = (state_ff == ST_DEC);
   assign rkey     = dec_mode ? key_low_inv : key_low_cur;

   lici_round u_round (
      .dec      (dec_mode),
      .left     (left_ff),
      .right    (right_ff),
      .rkey     (rkey),
      .left_nx  (left_nx),
      .right_nx (right_nx)
   );

   // sequencer, round counter, block halves and result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rnd_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  left_ff  <= req_left_in;
                  right_ff <= req_right_in;
                  rnd_ff   <= '0;
                  state_ff <= req_action ? ST_KEYF : ST_ENC;
               end
            end
            ST_ENC: begin
               left_ff  <= left_nx;
               right_ff <= right_nx;
               if (rnd_ff == LAST_RND) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end else begin
                  rnd_ff <= rnd_ff + 1'b1;
               end
            end
            ST_KEYF: begin
               // counter stays on the last round for the way back
               if (rnd_ff == LAST_RND) begin
                  state_ff <= ST_DEC;
               end else begin
                  rnd_ff <= rnd_ff + 1'b1;
               end
            end
            ST_DEC: begin
               left_ff  <= left_nx;
               right_ff <= right_nx;
               if (rnd_ff == FIRST_RND) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end else begin
                  rnd_ff <= rnd_ff - 1'b1;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = left_ff;
   assign rsp_right_out = right_ff;

   // checks on the sequencer
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without a request in flight");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("sequencer not idle in the result cycle");

   a_rnd_range: assert property (@(posedge clock) disable iff (reset)
      busy |-> (rnd_ff <= LAST_RND))
      else $error("round counter out of range");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

endmodule

// ----- verif/lici_tb_pkg.sv -----
`timescale 1ns / 100ps
// testbench-wide codes for the block cipher core: request actions, spare csr indexes
// depends on lici_pkg for the csr index width
package lici_tb_pkg;
   import lici_pkg::*;

   localparam int CIPHER_ROUNDS = 31;

   typedef enum logic {
      ACT_ENCRYPT = 1'b0,
      ACT_DECRYPT = 1'b1
   } action_type;

   // indexes that decode to no register
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_0 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_1 = 2'd3;

endpackage

// ----- verif/lici_cipher_checker.sv -----
`timescale 1ns / 100ps
// checker for the block cipher core: tracks the key registers, predicts each block and
// compares results in order; depends on lici_pkg and lici_tb_pkg
module lici_cipher_checker
   import lici_pkg::*;
   import lici_tb_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  logic                 req_action,
   input  logic [HALF_W-1:0]    req_left_in,
   input  logic [HALF_W-1:0]    req_right_in,
   input  logic                 rsp_valid,
   input  logic [HALF_W-1:0]    rsp_left_out,
   input  logic [HALF_W-1:0]    rsp_right_out,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [KWORD_W-1:0]   csr_data,
   output int                   fail_count,
   output int                   blocks_pending
);

   typedef struct packed {
      logic [HALF_W-1:0] left;
      logic [HALF_W-1:0] right;
   } block_type;

   // s-box and inverse, entry n in bits 4n+3..4n
   localparam logic [63:0] SBOX     = 64'h2174_8FE3_DA09_B65C;
   localparam logic [63:0] SBOX_INV = 64'hA970_364B_D21C_8FE5;

   logic [127:0] cipher_key;
   block_type    blocks_due[$];
   int           errors;

   function automatic logic [3:0] sub4(logic [63:0] tbl, logic [3:0] n);
      return tbl[{n, 2'b00} +: 4];
   endfunction

   function automatic logic [31:0] map_nibbles(logic [31:0] x, logic [63:0] tbl);
      logic [31:0] y;
      for (int s = 0; s < 32; s += 4)
         y[s +: 4] = sub4(tbl, x[s +: 4]);
      return y;
   endfunction

   function automatic logic [31:0] rol32(logic [31:0] x, int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic logic [31:0] ror32(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // five-bit round constant, zero past the end of the schedule
   function automatic logic [4:0] round_bits(int rnd);
      logic [7:0] raw;
      case (rnd)
         0: raw = 8'h01;   1: raw = 8'h02;   2: raw = 8'h04;   3: raw = 8'h08;
         4: raw = 8'h10;   5: raw = 8'h20;   6: raw = 8'h40;   7: raw = 8'h80;
         8: raw = 8'h13;   9: raw = 8'h23;  10: raw = 8'h43;  11: raw = 8'h83;
        12: raw = 8'h15;  13: raw = 8'h25;  14: raw = 8'h45;  15: raw = 8'h85;
        16: raw = 8'h16;  17: raw = 8'h26;  18: raw = 8'h46;  19: raw = 8'h86;
        20: raw = 8'h1A;  21: raw = 8'h2A;  22: raw = 8'h4A;  23: raw = 8'h8A;
        24: raw = 8'h1C;  25: raw = 8'h2C;  26: raw = 8'h4C;  27: raw = 8'h8C;
        28: raw = 8'h1F;  29: raw = 8'h2F;  30: raw = 8'h4F;
         default: raw = 8'h00;
      endcase
      return raw[4:0];
   endfunction

   // key update: rotate left 13, s-box on bits 7..4, constant into bits 63..59
   function automatic logic [127:0] key_fwd(logic [127:0] k, int rnd);
      k = {k[114:0], k[127:115]};
      k[7:4] = sub4(SBOX, k[7:4]);
      k[63:59] = k[63:59] ^ round_bits(rnd);
      return k;
   endfunction

   function automatic logic [127:0] key_back(logic [127:0] k, int rnd);
      k[63:59] = k[63:59] ^ round_bits(rnd);
      k[7:4] = sub4(SBOX_INV, k[7:4]);
      return {k[12:0], k[127:13]};
   endfunction

   function automatic block_type encrypt_block(block_type b, logic [127:0] k);
      logic [31:0] l, r, lp, nl;
      l = b.left;
      r = b.right;
      for (int i = 0; i < CIPHER_ROUNDS; i++) begin
         lp = map_nibbles(l, SBOX);
         nl = rol32(lp ^ r ^ k[31:0], 3);
         r = ror32(lp ^ nl ^ k[63:32], 7);
         l = nl;
         k = key_fwd(k, i);
      end
      return '{left: l, right: r};
   endfunction

   // walk the schedule to its end, then undo the rounds with the keys backwards
   function automatic block_type decrypt_block(block_type b, logic [127:0] k);
      logic [31:0] l, r, lp, pr;
      l = b.left;
      r = b.right;
      for (int i = 0; i < CIPHER_ROUNDS; i++)
         k = key_fwd(k, i);
      for (int i = CIPHER_ROUNDS - 1; i >= 0; i--) begin
         k = key_back(k, i);
         lp = rol32(r, 7) ^ k[63:32] ^ l;
         pr = ror32(l, 3) ^ lp ^ k[31:0];
         l = map_nibbles(lp, SBOX_INV);
         r = pr;
      end
      return '{left: l, right: r};
   endfunction

   always @(posedge clock) begin : watch
      block_type want;
      block_type blk;
      if (reset) begin
         cipher_key = '0;
      end else begin
         // key register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_KEY_HIGH: cipher_key[127:64] = csr_data;
               CSR_KEY_LOW:  cipher_key[63:0] = csr_data;
               default: ;
            endcase
         end
         // result against the oldest request
         if (rsp_valid) begin
            if (blocks_due.size() == 0) begin
               $error("result strobe with no request outstanding: left_out %08h right_out %08h",
                      rsp_left_out, rsp_right_out);
               errors++;
            end else begin
               want = blocks_due.pop_front();
               if (rsp_left_out !== want.left) begin
                  $error("left_out: expected %08h, actual %08h", want.left, rsp_left_out);
                  errors++;
               end
               if (rsp_right_out !== want.right) begin
                  $error("right_out: expected %08h, actual %08h", want.right, rsp_right_out);
                  errors++;
               end
            end
         end
         // accepted request
         if (start && !busy) begin
            blk = '{left: req_left_in, right: req_right_in};
            if (req_action == ACT_DECRYPT)
               blocks_due.push_back(decrypt_block(blk, cipher_key));
            else
               blocks_due.push_back(encrypt_block(blk, cipher_key));
         end
      end
      blocks_pending <= blocks_due.size();
      fail_count <= errors;
   end

endmodule

// ----- verif/tb_lici_block_cipher_enc_dec.sv -----
`timescale 1ns / 100ps
// stimulus and verdict for the block cipher core: directed blocks, then random bursts
// under a series of keys; depends on lici_pkg, lici_tb_pkg and lici_cipher_checker
module tb_lici_block_cipher_enc_dec;
   import lici_pkg::*;
   import lici_tb_pkg::*;

   localparam int PHASES          = 8;
   localparam int BLOCKS_PER_KEY  = 200;
   localparam int WATCHDOG_LIMIT  = 4000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic                 req_action = 1'b0;
   logic [HALF_W-1:0]    req_left_in = '0;
   logic [HALF_W-1:0]    req_right_in = '0;
   logic                 rsp_valid;
   logic [HALF_W-1:0]    rsp_left_out;
   logic [HALF_W-1:0]    rsp_right_out;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [KWORD_W-1:0]   csr_data = '0;

   int                   fail_count;
   int                   blocks_pending;
   int                   quiet_cycles = 0;
   logic [HALF_W-1:0]    last_left = '0;
   logic [HALF_W-1:0]    last_right = '0;

   always #4 clock = ~clock;

   lici_block_cipher_enc_dec #(.ROUNDS(CIPHER_ROUNDS)) DUT (.*);

   lici_cipher_checker checker_i (.*);

   // keep the latest result so that some requests can feed it back
   always @(posedge clock) begin
      if (rsp_valid) begin
         last_left <= rsp_left_out;
         last_right <= rsp_right_out;
      end
   end

   // watchdog on cycles with no handshake of any kind
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("lici_block_cipher_enc_dec test failed");
         $finish;
      end
   end

   // start stays high on return so that a burst can continue
   task automatic issue_block(action_type act, logic [HALF_W-1:0] l, logic [HALF_W-1:0] r);
      req_action <= act;
      req_left_in <= l;
      req_right_in <= r;
      start <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (blocks_pending != 0 || busy);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [KWORD_W-1:0] data);
      csr_index <= idx;
      csr_data <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
   endtask

   // both key words, in either order, optionally with a write to a spare index
   task automatic load_key(logic [KWORD_W-1:0] hi, logic [KWORD_W-1:0] lo, bit stray);
      if ($urandom_range(0, 1) != 0) begin
         write_csr(CSR_KEY_HIGH, hi);
         write_csr(CSR_KEY_LOW, lo);
      end else begin
         write_csr(CSR_KEY_LOW, lo);
         write_csr(CSR_KEY_HIGH, hi);
      end
      if (stray)
         write_csr(($urandom_range(0, 1) != 0) ? CSR_SPARE_1 : CSR_SPARE_0, {$urandom, $urandom});
      csr_valid <= 1'b0;
   endtask

   // all actions over the extreme and mixed block patterns
   task automatic directed_blocks();
      logic [HALF_W-1:0] pat_l [4];
      logic [HALF_W-1:0] pat_r [4];
      pat_l = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0123_4567};
      pat_r = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h89AB_CDEF};
      for (int i = 0; i < 4; i++) begin
         issue_block(ACT_ENCRYPT, pat_l[i], pat_r[i]);
         issue_block(ACT_DECRYPT, pat_l[i], pat_r[i]);
      end
   endtask

   task automatic random_block();
      action_type        act;
      logic [HALF_W-1:0] l;
      logic [HALF_W-1:0] r;
      act = action_type'($urandom_range(0, 1));
      l = $urandom;
      r = $urandom;
      case ($urandom_range(0, 9))
         0: l = '0;
         1: l = '1;
         2: r = '0;
         3: r = '1;
         // send a previous result back, often as its round trip
         4, 5: begin
            l = last_left;
            r = last_right;
         end
         default: ;
      endcase
      issue_block(act, l, r);
   endtask

   function automatic logic [KWORD_W-1:0] key_word();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   initial begin
      int sent;
      int burst;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: reset key, then all-ones key with a spare index write
      directed_blocks();
      wait_drained();
      load_key('1, '1, 1'b1);
      directed_blocks();

      // random bursts, one key per phase
      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         case (p)
            0: load_key('1, '0, 1'b0);
            1: load_key('0, '1, 1'b1);
            default: load_key(key_word(), key_word(), p[0]);
         endcase
         sent = 0;
         while (sent < BLOCKS_PER_KEY) begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && sent < BLOCKS_PER_KEY; i++) begin
               random_block();
               sent++;
            end
            // every third phase runs without gaps
            if (p % 3 != 2) begin
               case ($urandom_range(0, 9))
                  0, 1, 2: ;
                  3: wait_drained();
                  default: begin
                     start <= 1'b0;
                     repeat ($urandom_range(1, 90)) @(posedge clock);
                  end
               endcase
            end
         end
      end

      wait_drained();
      repeat (2 * CIPHER_ROUNDS + 8) @(posedge clock);
      if (fail_count == 0 && blocks_pending == 0)
         $display("lici_block_cipher_enc_dec test passed");
      else
         $display("lici_block_cipher_enc_dec test failed");
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/lici_pkg.sv
hw/rtl/lici_round.sv
hw/rtl/lici_key_unit.sv
hw/rtl/lici_block_cipher_enc_dec.sv
verif/lici_tb_pkg.sv
verif/lici_cipher_checker.sv
verif/tb_lici_block_cipher_enc_dec.sv
